[design/int8_outer_product_matmul_tile_macros.svh]
// assertion macros shared by the checker of the int8 outer-product tile
// depends on: clk and rst_n being visible where a macro is used
`ifndef INT8_OUTER_PRODUCT_MATMUL_TILE_MACROS_SVH
`define INT8_OUTER_PRODUCT_MATMUL_TILE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define IOPTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define IOPTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ioptm_pkg.sv]
// shared types, constants and helpers of the int8 outer-product tile
// depends on: nothing
`timescale 1ns / 1ps

package ioptm_pkg;

  localparam int TILE_ROWS = 16;
  localparam int TILE_COLS = 16;
  localparam int LANES     = 16;
  localparam int ROWS_HELD = (TILE_ROWS < LANES) ? TILE_ROWS : LANES;
  localparam int COLS_HELD = (TILE_COLS < LANES) ? TILE_COLS : LANES;
  localparam int ROW_IDX_W = (ROWS_HELD > 1) ? $clog2(ROWS_HELD) : 1;
  localparam int COUNT_W   = 5;
  localparam int ACC_W     = 32;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

  typedef logic [LANES-1:0][7:0]           lane_bytes_t;
  typedef logic [ACC_W-1:0]                acc_t;
  typedef acc_t [COLS_HELD-1:0]            acc_row_t;
  typedef acc_t [LANES-1:0]                sums_row_t;
  typedef logic [COUNT_W-1:0]              count_t;

  // per-step control fanned out to the lanes and the drain stage
  typedef struct packed {
    logic accept;
    logic last;
  } step_ctl_t;

  // zero counts as one, anything above the limit saturates
  function automatic count_t clamp_count(input count_t v, input count_t lim);
    count_t res;
    if (v == '0) begin
      res = count_t'(1);
    end else if (v > lim) begin
      res = lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[design/int8_outer_product_matmul_tile.sv]
// output: a taken last step fills the snapshot; the output register then takes row 0,
//   then one row per cycle while out_stall is low, rows_in_use rows in all
// throughput: one reduction step per cycle; a last step is held off (in_stall) while
//   the previous tile's snapshot is still draining
// reset: accumulators cleared, rows_in_use and cols_in_use back to 16, no clearing pass
`timescale 1ns / 1ps

module int8_outer_product_matmul_tile (
  input  logic                           clk,
  input  logic                           rst_n,
  // reduction step words
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [63:0]                    in_lhs_low,
  input  logic [63:0]                    in_lhs_high,
  input  logic [63:0]                    in_rhs_low,
  input  logic [63:0]                    in_rhs_high,
  input  logic                           in_last_step,
  // result words, one per tile row
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     out_row_index,
  output logic                           out_last_row,
  output logic [63:0]                    out_sums_0_1,
  output logic [63:0]                    out_sums_2_3,
  output logic [63:0]                    out_sums_4_5,
  output logic [63:0]                    out_sums_6_7,
  output logic [63:0]                    out_sums_8_9,
  output logic [63:0]                    out_sums_10_11,
  output logic [63:0]                    out_sums_12_13,
  output logic [63:0]                    out_sums_14_15,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ioptm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [4:0]                     cfg_data
);
  import ioptm_pkg::*;

  // config registers, taken at any time
  count_t      rows_cfg_r;
  count_t      cols_cfg_r;

  step_ctl_t   ctl;
  logic        drain_busy;
  lane_bytes_t lhs_bytes;
  lane_bytes_t rhs_bytes;
  acc_row_t    snap_rows [ROWS_HELD];
  sums_row_t   sums;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= count_t'(16);
      cols_cfg_r <= count_t'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS_IN_USE: rows_cfg_r <= cfg_data;
        REG_COLS_IN_USE: cols_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // only a last step has to wait for the snapshot to free up;
  // ordinary steps keep streaming into the live accumulators
  assign in_stall   = drain_busy && in_last_step;
  assign ctl.accept = in_valid && !in_stall;
  assign ctl.last   = in_last_step;

  // byte lanes: low word carries lanes 0-7, high word lanes 8-15
  assign lhs_bytes = {in_lhs_high, in_lhs_low};
  assign rhs_bytes = {in_rhs_high, in_rhs_low};

  // one lane per tile row, each doing a full row of the outer product
  for (genvar r = 0; r < ROWS_HELD; r++) begin : g_lane
    ioptm_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .lhs_byte  (lhs_bytes[r]),
      .rhs_bytes (rhs_bytes),
      .snap_row  (snap_rows[r])
    );
  end

  // merge stage: row-by-row readout of the snapshot into the output register
  ioptm_drain u_drain (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .rows_cfg      (rows_cfg_r),
    .cols_cfg      (cols_cfg_r),
    .snap_rows     (snap_rows),
    .busy          (drain_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_last_row  (out_last_row),
    .out_sums      (sums)
  );

  // column 2j in the low half, 2j+1 in the high half
  assign out_sums_0_1   = {sums[1],  sums[0]};
  assign out_sums_2_3   = {sums[3],  sums[2]};
  assign out_sums_4_5   = {sums[5],  sums[4]};
  assign out_sums_6_7   = {sums[7],  sums[6]};
  assign out_sums_8_9   = {sums[9],  sums[8]};
  assign out_sums_10_11 = {sums[11], sums[10]};
  assign out_sums_12_13 = {sums[13], sums[12]};
  assign out_sums_14_15 = {sums[15], sums[14]};

endmodule

[design/ioptm_lane.sv]
// one row lane: 16 signed 8x8 multipliers, 32-bit accumulators and the row snapshot
// depends on: ioptm_pkg
`timescale 1ns / 1ps

module ioptm_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ioptm_pkg::step_ctl_t   ctl,
  input  logic [7:0]             lhs_byte,
  input  ioptm_pkg::lane_bytes_t rhs_bytes,
  output ioptm_pkg::acc_row_t    snap_row
);
  import ioptm_pkg::*;

  acc_row_t          acc_r;
  acc_row_t          acc_sum;
  acc_row_t          snap_r;
  logic signed [15:0] prod [COLS_HELD];

  always_comb begin
    for (int c = 0; c < COLS_HELD; c++) begin
      prod[c]    = $signed(lhs_byte) * $signed(rhs_bytes[c]);
      acc_sum[c] = acc_r[c] + {{(ACC_W-16){prod[c][15]}}, prod[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.accept) begin
      acc_r <= ctl.last ? '0 : acc_sum;
    end
  end

  // finished tile row, held until the drain stage has sent it
  always_ff @(posedge clk) begin
    if (ctl.accept && ctl.last) begin
      snap_r <= acc_sum;
    end
  end

  assign snap_row = snap_r;

endmodule

[design/ioptm_drain.sv]
// merge stage: walks the snapshot rows, masks unused columns, output register
// depends on: ioptm_pkg
`timescale 1ns / 1ps

module ioptm_drain (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ioptm_pkg::step_ctl_t    ctl,
  input  ioptm_pkg::count_t       rows_cfg,
  input  ioptm_pkg::count_t       cols_cfg,
  input  ioptm_pkg::acc_row_t     snap_rows [ioptm_pkg::ROWS_HELD],
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              out_row_index,
  output logic                    out_last_row,
  output ioptm_pkg::sums_row_t    out_sums
);
  import ioptm_pkg::*;

  logic                 busy_r;
  logic [ROW_IDX_W-1:0] row_cnt_r;
  logic [ROW_IDX_W-1:0] row_cnt_nxt;
  count_t               rows_r;
  count_t               cols_r;
  logic                 out_valid_r;
  logic [3:0]           out_row_index_r;
  logic                 out_last_row_r;
  sums_row_t            out_sums_r;
  sums_row_t            sums_nxt;
  acc_row_t             sel_row;
  logic                 load;
  logic                 row_last;

  assign load        = busy_r && (!out_valid_r || !out_stall);
  assign row_last    = (count_t'(row_cnt_r) + count_t'(1)) == rows_r;
  assign row_cnt_nxt = row_cnt_r + 1'b1;

  always_comb begin
    sel_row  = snap_rows[row_cnt_r];
    sums_nxt = '0;
    for (int c = 0; c < COLS_HELD; c++) begin
      if (count_t'(c) < cols_r) begin
        sums_nxt[c] = sel_row[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      row_cnt_r   <= '0;
      rows_r      <= count_t'(ROWS_HELD);
      cols_r      <= count_t'(COLS_HELD);
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.accept && ctl.last) begin
        busy_r    <= 1'b1;
        row_cnt_r <= '0;
        rows_r    <= clamp_count(rows_cfg, count_t'(ROWS_HELD));
        cols_r    <= clamp_count(cols_cfg, count_t'(COLS_HELD));
      end else if (load) begin
        row_cnt_r <= row_cnt_nxt;
        if (row_last) begin
          busy_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_index_r <= 4'(row_cnt_r);
      out_last_row_r  <= row_last;
      out_sums_r      <= sums_nxt;
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_index_r;
  assign out_last_row  = out_last_row_r;
  assign out_sums      = out_sums_r;

endmodule

[design/ioptm_checker.sv]
// port-level checks for the int8 outer-product tile, bound to the top level
// depends on: int8_outer_product_matmul_tile_macros.svh
`timescale 1ns / 1ps
`include "int8_outer_product_matmul_tile_macros.svh"

module ioptm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last_step,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_row_index,
  input logic       out_last_row,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  logic       row_taken;
  logic [3:0] idx_inc;

  assign row_taken = out_valid && !out_stall && !out_last_row;
  assign idx_inc   = out_row_index + 4'd1;

  // a stalled result word stays offered
  `IOPTM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")

  // rows of one tile come back to back in ascending order
  `IOPTM_ASSERT_NEXT(a_row_seq, row_taken, out_valid && out_row_index == $past(idx_inc), "row order")

  // a stalled step word stays offered
  `IOPTM_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid, "stalled step word withdrawn")

  // only a last step is ever held off
  `IOPTM_ASSERT_NOW(a_stall_last, in_stall, in_last_step, "ordinary step stalled")

  // config writes are never refused
  `IOPTM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind int8_outer_product_matmul_tile ioptm_checker u_ioptm_checker (.*);

[tb/sv/int8_outer_product_matmul_tile_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for the int8 outer-product tile: a directed table, then random
// reduction-step words, scored against an accumulator model kept inside the bench or hand-computed sums
// depends on: ioptm_pkg and the int8_outer_product_matmul_tile rtl

module int8_outer_product_matmul_tile_tb;
  import ioptm_pkg::*;

  localparam int SETTLE_CYCLES = 8;     // lets in-flight accumulation land before a cfg write
  localparam int TAIL_CYCLES   = 40;    // room for a stray row word after the last expected one
  localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake before giving up
  localparam int PAIRS         = LANES / 2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd2;

  typedef enum logic { ROW_STEP, ROW_WRITE } stim_kind_t;

  // one line of the directed table: either a step word or a register write
  typedef struct {
    stim_kind_t            kind;
    logic [63:0]           lhs_low;
    logic [63:0]           lhs_high;
    logic [63:0]           rhs_low;
    logic [63:0]           rhs_high;
    logic                  last;
    logic                  has_typed;
    logic [31:0]           typed;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [4:0]            reg_val;
  } stim_row_t;

  // hand-computed sum for a single-step tile, used in place of the model
  typedef struct packed {
    logic        valid;
    logic [31:0] value;
  } typed_sum_t;

  // one row word as the tile should emit it
  typedef struct packed {
    logic [3:0]             row_index;
    logic                   last_row;
    logic [PAIRS-1:0][63:0] sums;
  } tile_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [63:0]          in_lhs_low = '0;
  logic [63:0]          in_lhs_high = '0;
  logic [63:0]          in_rhs_low = '0;
  logic [63:0]          in_rhs_high = '0;
  logic                 in_last_step = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [3:0]           out_row_index;
  logic                 out_last_row;
  logic [63:0]          out_sums_0_1;
  logic [63:0]          out_sums_2_3;
  logic [63:0]          out_sums_4_5;
  logic [63:0]          out_sums_6_7;
  logic [63:0]          out_sums_8_9;
  logic [63:0]          out_sums_10_11;
  logic [63:0]          out_sums_12_13;
  logic [63:0]          out_sums_14_15;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS_IN_USE;
  logic [4:0]           cfg_data = '0;

  // bench copy of the tile state and its two registers
  acc_t       tile_acc [ROWS_HELD][COLS_HELD];
  count_t     rows_cfg;
  count_t     cols_cfg;

  tile_row_t  rows_due_q [$];
  typed_sum_t typed_sum_q [$];
  stim_row_t  directed_q [$];

  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       word_moved;

  int8_outer_product_matmul_tile u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_lhs_low     (in_lhs_low),
    .in_lhs_high    (in_lhs_high),
    .in_rhs_low     (in_rhs_low),
    .in_rhs_high    (in_rhs_high),
    .in_last_step   (in_last_step),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_index  (out_row_index),
    .out_last_row   (out_last_row),
    .out_sums_0_1   (out_sums_0_1),
    .out_sums_2_3   (out_sums_2_3),
    .out_sums_4_5   (out_sums_4_5),
    .out_sums_6_7   (out_sums_6_7),
    .out_sums_8_9   (out_sums_8_9),
    .out_sums_10_11 (out_sums_10_11),
    .out_sums_12_13 (out_sums_12_13),
    .out_sums_14_15 (out_sums_14_15),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // model side
  // ---------------------------------------------------------------------------

  // zero reads as one, anything past the array saturates
  function automatic int limit_count(input count_t v, input int cap);
    if (v == '0) begin
      return 1;
    end
    return (v > cap) ? cap : int'(v);
  endfunction

  // accumulate one outer product; on the last step queue the emitted rows and clear
  task automatic accumulate_step(input logic [63:0] lhs_lo, input logic [63:0] lhs_hi,
                                 input logic [63:0] rhs_lo, input logic [63:0] rhs_hi,
                                 input logic last);
    logic [127:0] lhs_all;
    logic [127:0] rhs_all;
    byte          a;
    byte          b;
    int           prod;
    int           r;
    int           c;
    int           rows;
    int           cols;
    typed_sum_t   tsum;
    tile_row_t    due;
    logic [31:0]  lane;
    lhs_all = {lhs_hi, lhs_lo};
    rhs_all = {rhs_hi, rhs_lo};
    for (r = 0; r < ROWS_HELD; r++) begin
      for (c = 0; c < COLS_HELD; c++) begin
        a = lhs_all[8*r +: 8];
        b = rhs_all[8*c +: 8];
        prod = a * b;
        tile_acc[r][c] = tile_acc[r][c] + 32'(prod);   // wraps mod 2^32
      end
    end
    if (!last) begin
      return;
    end
    // the driver queued one entry per last step before it could be taken
    tsum = (typed_sum_q.size() != 0) ? typed_sum_q.pop_front() : '0;
    // registers as they stand now decide the shape of the drain
    rows = limit_count(rows_cfg, ROWS_HELD);
    cols = limit_count(cols_cfg, COLS_HELD);
    for (r = 0; r < rows; r++) begin
      due = '0;
      due.row_index = 4'(r);
      due.last_row  = (r == rows - 1);
      for (c = 0; c < LANES; c++) begin
        lane = '0;
        if (c < cols) begin
          lane = tsum.valid ? tsum.value : tile_acc[r][c];
        end
        due.sums[c/2][32*(c%2) +: 32] = lane;
      end
      rows_due_q.push_back(due);
    end
    // rows past rows_in_use are dropped but still cleared
    for (r = 0; r < ROWS_HELD; r++) begin
      for (c = 0; c < COLS_HELD; c++) begin
        tile_acc[r][c] = '0;
      end
    end
  endtask

  // score one row word against the oldest expectation
  task automatic check_row();
    tile_row_t              want;
    logic [PAIRS-1:0][63:0] seen;
    int                     p;
    seen = {out_sums_14_15, out_sums_12_13, out_sums_10_11, out_sums_8_9,
            out_sums_6_7, out_sums_4_5, out_sums_2_3, out_sums_0_1};
    if (rows_due_q.size() == 0) begin
      $display("%0t: row word with none expected: expected nothing, got row %0d last %0b",
               $time, out_row_index, out_last_row);
      mismatch_count++;
      return;
    end
    want = rows_due_q.pop_front();
    if (out_row_index !== want.row_index) begin
      $display("%0t: row_index expected %0d got %0d", $time, want.row_index, out_row_index);
      mismatch_count++;
    end
    if (out_last_row !== want.last_row) begin
      $display("%0t: row %0d last_row expected %0b got %0b",
               $time, want.row_index, want.last_row, out_last_row);
      mismatch_count++;
    end
    for (p = 0; p < PAIRS; p++) begin
      if (seen[p] !== want.sums[p]) begin
        $display("%0t: row %0d sums_%0d_%0d expected %h got %h",
                 $time, want.row_index, 2*p, 2*p+1, want.sums[p], seen[p]);
        mismatch_count++;
      end
    end
  endtask

  // every handshake is observed here; prediction goes first so a same-edge row
  // of an older tile still finds its expectation at the head of the queue
  always @(posedge clk) begin
    if (rst_n) begin
      word_moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        word_moved = 1'b1;
        if (cfg_index == REG_ROWS_IN_USE) begin
          rows_cfg = cfg_data;
        end else if (cfg_index == REG_COLS_IN_USE) begin
          cols_cfg = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        word_moved = 1'b1;
        accumulate_step(in_lhs_low, in_lhs_high, in_rhs_low, in_rhs_high, in_last_step);
      end
      if (out_valid && !out_stall) begin
        word_moved = 1'b1;
        check_row();
      end
      quiet_cycles = word_moved ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog, sampled away from the active edge
  initial begin
    do @(negedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] bytes_of(input logic [7:0] b);
    return {8{b}};
  endfunction

  // eight lanes, each biased toward the signed extremes, zero and minus one
  function automatic logic [63:0] rand_lanes();
    logic [63:0] w;
    int          k;
    for (k = 0; k < 8; k++) begin
      case ($urandom_range(7))
        0: w[8*k +: 8] = 8'h80;
        1: w[8*k +: 8] = 8'h7f;
        2: w[8*k +: 8] = 8'h00;
        3: w[8*k +: 8] = 8'hff;
        default: w[8*k +: 8] = 8'($urandom);
      endcase
    end
    return w;
  endfunction

  // register value: in range mostly, with zero, one, full and saturating values
  function automatic logic [4:0] pick_count();
    case ($urandom_range(9))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  // reduction length: short tiles mostly, an occasional long one
  function automatic int pick_tile_len();
    return ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
  endfunction

  task automatic add_step(input logic [63:0] ll, input logic [63:0] lh,
                          input logic [63:0] rl, input logic [63:0] rh,
                          input logic last, input logic has_typed, input logic [31:0] typed);
    stim_row_t s;
    s = '{ROW_STEP, ll, lh, rl, rh, last, has_typed, typed, REG_ROWS_IN_USE, 5'd0};
    directed_q.push_back(s);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] val);
    stim_row_t s;
    s = '{ROW_WRITE, '0, '0, '0, '0, 1'b0, 1'b0, '0, idx, val};
    directed_q.push_back(s);
  endtask

  // drive one step word and hold it until taken; valid is left high on return
  task automatic send_step(input logic [63:0] ll, input logic [63:0] lh,
                           input logic [63:0] rl, input logic [63:0] rh,
                           input logic last, input logic has_typed, input logic [31:0] typed);
    typed_sum_t t;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_lhs_low   <= ll;
    in_lhs_high  <= lh;
    in_rhs_low   <= rl;
    in_rhs_high  <= rh;
    in_last_step <= last;
    if (last) begin
      t.valid = has_typed;
      t.value = typed;
      typed_sum_q.push_back(t);
    end
    do @(posedge clk); while (in_stall);
  endtask

  // hold the sender until every queued row is out and the tile has gone quiet
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    // let the monitor see the clock edge first, so it has queued the rows of a step taken just now
    @(posedge clk);
    while (rows_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int i;
    int r;
    int c;
    int ph;
    int seg;
    int n;
    int steps_left;
    rows_cfg = count_t'(16);
    cols_cfg = count_t'(16);
    for (r = 0; r < ROWS_HELD; r++) begin
      for (c = 0; c < COLS_HELD; c++) begin
        tile_acc[r][c] = '0;
      end
    end
    steps_left = 0;

    // single-step tiles at the corners of the int8 product, plus zero and -1 times 1, reset shape 16x16
    add_step(bytes_of(8'h7f), bytes_of(8'h7f), bytes_of(8'h7f), bytes_of(8'h7f),
             1'b1, 1'b1, 32'h0000_3f01);
    add_step(bytes_of(8'h80), bytes_of(8'h80), bytes_of(8'h80), bytes_of(8'h80),
             1'b1, 1'b1, 32'h0000_4000);
    add_step(bytes_of(8'h80), bytes_of(8'h80), bytes_of(8'h7f), bytes_of(8'h7f),
             1'b1, 1'b1, 32'hffff_c080);
    add_step(bytes_of(8'h7f), bytes_of(8'h7f), bytes_of(8'h80), bytes_of(8'h80),
             1'b1, 1'b1, 32'hffff_c080);
    add_step('0, '0, '0, '0, 1'b1, 1'b1, 32'h0);
    add_step(bytes_of(8'hff), bytes_of(8'hff), bytes_of(8'h01), bytes_of(8'h01),
             1'b1, 1'b1, 32'hffff_ffff);
    // three-step tile; the first two steps carry a distinct lhs byte in every lane
    add_step(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
             64'h55aa_55aa_55aa_55aa, 64'haa55_aa55_aa55_aa55, 1'b0, 1'b0, '0);
    add_step(64'hfedc_ba98_7654_3210, 64'h0123_4567_89ab_cdef,
             64'h8001_7f80_ff00_0180, 64'h807f_0180_00ff_7f01, 1'b0, 1'b0, '0);
    add_step(64'h8080_7f7f_0101_ffff, 64'h7f7f_8080_ffff_0101,
             64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321, 1'b1, 1'b0, '0);
    // smallest shape
    add_write(REG_ROWS_IN_USE, 5'd1);
    add_write(REG_COLS_IN_USE, 5'd1);
    add_step(bytes_of(8'h7f), bytes_of(8'h7f), bytes_of(8'h7f), bytes_of(8'h7f),
             1'b1, 1'b1, 32'h0000_3f01);
    // zero in a register reads as one
    add_write(REG_ROWS_IN_USE, 5'd0);
    add_write(REG_COLS_IN_USE, 5'd0);
    add_step(bytes_of(8'h80), bytes_of(8'h80), bytes_of(8'h80), bytes_of(8'h80),
             1'b1, 1'b1, 32'h0000_4000);
    // oversized values saturate; a write to an unmapped index must change nothing
    add_write(REG_ROWS_IN_USE, 5'd31);
    add_write(REG_COLS_IN_USE, 5'd17);
    add_write(REG_UNMAPPED, 5'd2);
    add_step(bytes_of(8'h80), bytes_of(8'h80), bytes_of(8'h7f), bytes_of(8'h7f),
             1'b1, 1'b1, 32'hffff_c080);
    // shape changed in the middle of a tile: the values at the last step win
    add_step(64'h7f80_01ff_2ad6_9c64, 64'h0080_ff7f_1e2d_3c4b,
             64'hc3a5_5a3c_0180_7fff, 64'h9966_33cc_80ff_017f, 1'b0, 1'b0, '0);
    add_write(REG_ROWS_IN_USE, 5'd5);
    add_write(REG_COLS_IN_USE, 5'd3);
    add_step(64'h8000_7f01_ff80_0ff0, 64'hf00f_80ff_017f_0080,
             64'h7f7f_8080_0102_0304, 64'h0506_0708_fffe_fdfc, 1'b1, 1'b0, '0);

    // first idling pattern covers the directed table as well
    send_idle_pct  = 14;
    recv_stall_pct = 54;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < directed_q.size(); i++) begin
      if (directed_q[i].kind == ROW_WRITE) begin
        drain_and_settle();
        write_reg(directed_q[i].reg_idx, directed_q[i].reg_val);
      end else begin
        send_step(directed_q[i].lhs_low, directed_q[i].lhs_high,
                  directed_q[i].rhs_low, directed_q[i].rhs_high,
                  directed_q[i].last, directed_q[i].has_typed, directed_q[i].typed);
      end
    end

    // random part: three idling patterns, three register settings in each;
    // a setting may land mid-tile, which the tile has to honor at the last step
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 14;
          recv_stall_pct = 54;
        end
        1: begin
          send_idle_pct  = 54;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (seg = 0; seg < 3; seg++) begin
        drain_and_settle();
        write_reg(REG_ROWS_IN_USE, pick_count());
        write_reg(REG_COLS_IN_USE, pick_count());
        for (n = 0; n < 47; n++) begin
          if (steps_left == 0) begin
            steps_left = pick_tile_len();
          end
          steps_left--;
          send_step(rand_lanes(), rand_lanes(), rand_lanes(), rand_lanes(),
                    steps_left == 0, 1'b0, '0);
          // now and then the sender waits out the whole drain
          if (steps_left == 0 && $urandom_range(39) == 0) begin
            drain_and_settle();
          end
        end
      end
    end

    drain_and_settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
